// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

   localparam int PATTERN_MAX = 512;
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int PIDX_W      = 9;
   localparam int LEN_W       = 9;
   localparam int ADDR_W      = 64;
   localparam int CMP_W       = ((IDX_W > PIDX_W) ? IDX_W : PIDX_W) + 1;
   localparam int GROUP_W     = 16;
   localparam int NUM_GROUPS  = (PATTERN_MAX + GROUP_W - 1) / GROUP_W;
   localparam int CSR_IDX_W   = 2;

   localparam logic [7:0] WILDCARD = 8'hFF;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_REGION_BASE    = 2'd1,
      CSR_RESULT_OFFSET  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              mode;
      logic [PIDX_W-1:0] pattern_index;
      logic [7:0]        data_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_payload_type;

   typedef struct packed {
      logic              load;
      logic              scan;
      logic [PIDX_W-1:0] pattern_index;
      logic [7:0]        data_byte;
      logic [LEN_W-1:0]  length;
   } cell_ctl_type;

endpackage

// ===== rtl/wbps_cell.sv =====
module wbps_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [wbps_pkg::IDX_W-1:0] cell_index,
   input  wbps_pkg::cell_ctl_type     ctl,
   input  logic                       prev_match,
   output logic                       match,
   output logic                       tail_hit
);

   logic [7:0] pat_ff;
   logic       match_ff;
   logic       match_in;
   logic       idx_hit;
   logic       is_tail;
   logic       byte_ok;

   assign idx_hit = (wbps_pkg::CMP_W'(ctl.pattern_index) == wbps_pkg::CMP_W'(cell_index));
   assign is_tail = (wbps_pkg::CMP_W'(ctl.length) ==
                     wbps_pkg::CMP_W'(cell_index) + wbps_pkg::CMP_W'(1));
   assign byte_ok = (pat_ff == wbps_pkg::WILDCARD) || (pat_ff == ctl.data_byte);
   assign match_in = prev_match & byte_ok;

   always_ff @(posedge clock) begin
      if (ctl.load && idx_hit) begin
         pat_ff <= ctl.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.scan) begin
         match_ff <= match_in;
      end
   end

   assign match    = match_ff;
   assign tail_hit = match_ff & is_tail;

endmodule

// ===== rtl/wbps_hit_tree.sv =====
module wbps_hit_tree (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [wbps_pkg::PATTERN_MAX-1:0] tail_hits,
   output logic                             hit
);

   localparam int PAD_W = wbps_pkg::NUM_GROUPS * wbps_pkg::GROUP_W;

   logic [PAD_W-1:0]                   padded;
   logic [wbps_pkg::NUM_GROUPS-1:0]    group_in;
   logic [wbps_pkg::NUM_GROUPS-1:0]    group_ff;

   assign padded = PAD_W'(tail_hits);

   always_comb begin
      for (int g = 0; g < wbps_pkg::NUM_GROUPS; g++) begin
         group_in[g] = |padded[g*wbps_pkg::GROUP_W +: wbps_pkg::GROUP_W];
      end
   end

   // first level of the OR tree is registered, second level feeds the state update
   always_ff @(posedge clock) begin
      if (enable) begin
         group_ff <= group_in;
      end
   end

   assign hit = |group_ff;

endmodule

// ===== rtl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search.
// Input channel req_*: each transaction either loads one pattern byte (mode 0,
// at pattern_index; 0xFF matches any byte) or scans one region byte (mode 1).
// A scan transaction with last_byte set closes the region and produces one
// transaction on rsp_*: found and match_address = base + match start + offset.
// Configuration port csr_*: pattern_length, region_base, result_offset,
// written while no scan is in flight (csr_ready drops while one is, and while
// req_valid is high).
// Throughput: one transaction per cycle while req_stall is low, loads and
// scans alike. Every pattern position is a cell that updates its partial
// match on each scanned byte. After the last byte is accepted, the result
// passes the cell row, the registered first level of the end-of-pattern OR
// tree and the output register before it is presented.
// Reset clears the configuration, partial matches and scan position; pattern
// bytes hold no defined value until loaded.
// When rsp_stall holds a result and another finished result is due, req_stall
// rises and the whole pipeline holds until the output register is free.
module wildcard_byte_pattern_search (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wbps_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wbps_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wbps_pkg::ADDR_W-1:0]            csr_data
);

   logic [wbps_pkg::LEN_W-1:0]  len_ff;
   logic [wbps_pkg::ADDR_W-1:0] base_ff;
   logic [wbps_pkg::ADDR_W-1:0] offset_ff;

   logic [wbps_pkg::ADDR_W-1:0] pos_ff;
   logic                        restart_ff;

   logic                        s1_valid_ff;
   logic                        s1_last_ff;
   logic [wbps_pkg::ADDR_W-1:0] s1_cand_ff;
   logic                        s2_valid_ff;
   logic                        s2_last_ff;
   logic [wbps_pkg::ADDR_W-1:0] s2_cand_ff;

   logic                        seen_ff;
   logic [wbps_pkg::ADDR_W-1:0] start_ff;

   logic                        rsp_valid_ff;
   wbps_pkg::rsp_payload_type   rsp_ff;

   logic                        enable;
   logic                        req_acc;
   logic                        scan_acc;
   logic                        csr_acc;
   logic                        hit;
   logic                        len_ok;
   logic                        seen_in;
   logic [wbps_pkg::ADDR_W-1:0] start_in;
   logic [wbps_pkg::ADDR_W-1:0] cand_in;
   logic                        ok;
   wbps_pkg::rsp_payload_type   rsp_in;
   wbps_pkg::cell_ctl_type      ctl;

   logic [wbps_pkg::PATTERN_MAX-1:0] cell_match;
   logic [wbps_pkg::PATTERN_MAX-1:0] cell_prev;
   logic [wbps_pkg::PATTERN_MAX-1:0] tail_hits;

   // hold everything while a finished result waits behind a stalled one
   assign enable    = !(rsp_valid_ff && rsp_stall && s2_valid_ff && s2_last_ff);
   assign req_stall = !enable;
   assign req_acc   = req_valid && enable;
   assign scan_acc  = req_acc && (req_payload.mode == wbps_pkg::MODE_SCAN);
   assign csr_ready = !(s1_valid_ff || s2_valid_ff || req_valid);
   assign csr_acc   = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         base_ff   <= '0;
         offset_ff <= '0;
      end else if (csr_acc) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_LENGTH: len_ff    <= csr_data[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CSR_REGION_BASE:    base_ff   <= csr_data;
            wbps_pkg::CSR_RESULT_OFFSET:  offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ctl.load          = req_acc && (req_payload.mode == wbps_pkg::MODE_LOAD);
   assign ctl.scan          = scan_acc;
   assign ctl.pattern_index = req_payload.pattern_index;
   assign ctl.data_byte     = req_payload.data_byte;
   assign ctl.length        = len_ff;

   for (genvar j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin : g_cell
      if (j == 0) begin : g_head
         assign cell_prev[j] = 1'b1;
      end else begin : g_body
         assign cell_prev[j] = cell_match[j-1] & ~restart_ff;
      end
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (wbps_pkg::IDX_W'(j)),
         .ctl        (ctl),
         .prev_match (cell_prev[j]),
         .match      (cell_match[j]),
         .tail_hit   (tail_hits[j])
      );
   end

   wbps_hit_tree u_hit_tree (
      .clock     (clock),
      .enable    (enable),
      .tail_hits (tail_hits),
      .hit       (hit)
   );

   // start of a match ending on this byte
   assign cand_in = pos_ff - wbps_pkg::ADDR_W'(len_ff) + wbps_pkg::ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         restart_ff <= 1'b0;
      end else if (scan_acc) begin
         pos_ff     <= req_payload.last_byte ? '0 : pos_ff + wbps_pkg::ADDR_W'(1);
         restart_ff <= req_payload.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= scan_acc;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_last_ff <= req_payload.last_byte;
         s1_cand_ff <= cand_in;
         s2_last_ff <= s1_last_ff;
         s2_cand_ff <= s1_cand_ff;
      end
   end

   assign len_ok   = (len_ff != '0) && (32'(len_ff) < wbps_pkg::PATTERN_MAX);
   assign seen_in  = seen_ff || (hit && len_ok);
   assign start_in = seen_ff ? start_ff : s2_cand_ff;
   assign ok       = seen_in && (base_ff != '0);

   always_comb begin
      rsp_in.found         = ok;
      rsp_in.match_address = ok ? (base_ff + start_in + offset_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         start_ff <= '0;
      end else if (enable && s2_valid_ff) begin
         if (s2_last_ff) begin
            seen_ff  <= 1'b0;
            start_ff <= '0;
         end else begin
            seen_ff  <= seen_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable && s2_valid_ff && s2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && s2_valid_ff && s2_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && s2_valid_ff && s2_last_ff))
      else $error("input held without a pending result");

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (scan_acc && req_payload.last_byte) |=> (pos_ff == '0 && restart_ff))
      else $error("scan position not cleared after last byte");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.match_address == '0))
      else $error("address given without a match");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result without a closing byte");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      !enable |=> ($stable(s2_cand_ff) && $stable(s2_last_ff)))
      else $error("pipeline advanced while held");
`endif

endmodule
